### rtl/awu_pkg.sv
package awu_pkg;

    localparam int ENTRIES_DEF = 4096;
    localparam int IDX_W       = 12;
    localparam int MOD_SHIFT   = 24;

    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [31:0] B1_Q32   = 32'd3865470566;
    localparam logic [31:0] OMB1_Q32 = 32'd429496730;
    localparam logic [31:0] B2_Q32   = 32'd4290672329;
    localparam logic [31:0] OMB2_Q32 = 32'd4294967;
    localparam logic [31:0] LR_RESET = 32'd4294967;

    localparam int D_STAGES = 62;
    localparam int M_STAGES = 38;
    localparam int S_STAGES = 35;
    localparam int R_STAGES = 62;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [31:0]      w;
        logic             neg;
        logic             nostep;
    } t_tag;

endpackage

### rtl/awu_if.sv
interface awu_in_if import awu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [31:0]      weight_in;
    logic [31:0]      gradient;
    logic             new_step;

    modport source (output valid, index, weight_in, gradient, new_step, input ready);
    modport sink (input valid, index, weight_in, gradient, new_step, output ready);
endinterface

interface awu_out_if import awu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index_out;
    logic [31:0]      weight_out;

    modport source (output valid, index_out, weight_out, input ready);
    modport sink (input valid, index_out, weight_out, output ready);
endinterface

interface awu_cfg_if ();
    logic        valid;
    logic        ready;
    logic [31:0] step_size;

    modport source (output valid, step_size, input ready);
    modport sink (input valid, step_size, output ready);
endinterface

### rtl/adam_weight_update.sv
// fixed-point adam optimizer, one parameter element per transaction
// i_item: index, weight_in, gradient, new_step; new_step advances the shared
//   beta1/beta2 powers before this element is updated
// o_result: index_out echoes the raw index, weight_out is the saturated new weight
// i_cfg: step size write, always ready, takes effect for elements that reach the step size
//   scaling after it, in flight or later; throughput: one element per cycle while not
//   stalled; moments live in two one-port-read memories, updated in a single
//   read-modify-write stage with forwarding of the last write, so repeated indexes need no stall
// path: o_result.valid follows the accept, address and read-modify-write registers,
//   the bit-serial pipelines for the two bias corrections, the square root
//   and the final ratio, the step size scaling registers and the output register
// reset: powers return to one, step size to its default, and a clear pass
//   zeroes every address of both memories while i_item.ready is low
// stall: the pipeline keeps accepting while a result waits in the output
//   register; it freezes only when a second result is ready right behind it
module adam_weight_update import awu_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    awu_cfg_if.sink     i_cfg,
    awu_in_if.sink      i_item,
    awu_out_if.source   o_result
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned RECIP = (32'd1 << MOD_SHIFT) / ENTRIES;

    logic        en;
    logic        acc;
    logic [31:0] r_lr;
    logic [31:0] r_b1;
    logic [31:0] r_b2;
    logic [31:0] n_b1;
    logic [31:0] n_b2;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic [31:0] mem_m [ENTRIES];
    logic [47:0] mem_v [ENTRIES];
    logic [31:0] r_rd_m;
    logic [47:0] r_rd_v;

    // accept stage
    logic [31:0] gmag;
    logic [63:0] gsq;
    logic [36:0] mod_q;

    logic             r_vld_p;
    logic [IDX_W-1:0] r_idx_p;
    logic [31:0]      r_w_p;
    logic             r_gneg_p;
    logic [31:0]      r_gm1_p;
    logic [54:0]      r_g2_p;
    logic [31:0]      r_b1_p;
    logic [31:0]      r_b2_p;
    logic [IDX_W-1:0] r_q0_p;

    logic [28:0]   mod_prod;
    logic [28:0]   mod_diff;
    logic [28:0]   mod_e;
    logic [AW-1:0] e_p;

    logic             r_vld_a;
    logic [IDX_W-1:0] r_idx_a;
    logic [31:0]      r_w_a;
    logic [AW-1:0]    r_e_a;
    logic             r_gneg_a;
    logic [31:0]      r_gm1_a;
    logic [45:0]      r_gv_a;
    logic [31:0]      r_d1_a;
    logic [31:0]      r_d2_a;

    logic          r_h_vld;
    logic [AW-1:0] r_h_e;
    logic [31:0]   r_h_m;
    logic [47:0]   r_h_v;

    // read-modify-write stage
    logic               fwd;
    logic [31:0]        m_old;
    logic [47:0]        v_old;
    logic [31:0]        mmag_old;
    logic [31:0]        pm;
    logic signed [33:0] tm;
    logic signed [33:0] tg;
    logic signed [33:0] sm;
    logic [31:0]        m_new;
    logic [70:0]        vx;
    logic [47:0]        pv;
    logic [48:0]        vs;
    logic [47:0]        v_new;

    logic        r_vld_x;
    t_tag        r_tag_x;
    logic [31:0] r_mmag_x;
    logic [47:0] r_v_x;
    logic [31:0] r_d1_x;
    logic [31:0] r_d2_x;

    // bias-correction dividers
    logic [D_STAGES-1:0] r_vld_d;
    t_tag        r_tag_d  [D_STAGES];
    logic [31:0] r_vrem_d [D_STAGES];
    logic [61:0] r_vn_d   [D_STAGES];
    logic [61:0] r_vq_d   [D_STAGES];
    logic [31:0] r_d2_d   [D_STAGES];
    logic        r_vsat_d [D_STAGES];
    logic [31:0] r_mrem_d [D_STAGES];
    logic [37:0] r_mn_d   [D_STAGES];
    logic [37:0] r_mq_d   [D_STAGES];
    logic [31:0] r_d1_d   [D_STAGES];
    logic        r_msat_d [D_STAGES];

    // square root
    logic [S_STAGES-1:0] r_vld_s;
    t_tag        r_tag_s  [S_STAGES];
    logic [37:0] r_rem_s  [S_STAGES];
    logic [69:0] r_sn_s   [S_STAGES];
    logic [34:0] r_root_s [S_STAGES];
    logic [37:0] r_mhat_s [S_STAGES];

    // ratio divider
    logic [R_STAGES-1:0] r_vld_r;
    t_tag        r_tag_r [R_STAGES];
    logic [35:0] r_rem_r [R_STAGES];
    logic [61:0] r_rn_r  [R_STAGES];
    logic [61:0] r_q_r   [R_STAGES];
    logic [35:0] r_den_r [R_STAGES];

    logic        r_vld_m1;
    t_tag        r_tag_m1;
    logic [63:0] r_lo_m1;
    logic [61:0] r_hi_m1;

    logic        r_vld_m2;
    t_tag        r_tag_m2;
    logic [62:0] r_step_m2;

    logic signed [64:0] wx;
    logic signed [64:0] sx;
    logic signed [64:0] rs;
    logic [31:0]        res;

    logic             r_out_vld;
    logic [IDX_W-1:0] r_out_idx;
    logic [31:0]      r_out_w;

    assign en  = !(r_vld_m2 && r_out_vld && !o_result.ready);
    assign acc = i_item.valid && i_item.ready;

    assign i_item.ready = en && !r_clr_busy;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid      = r_out_vld;
    assign o_result.index_out  = r_out_idx;
    assign o_result.weight_out = r_out_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= LR_RESET;
        end else if (i_cfg.valid) begin
            r_lr <= i_cfg.step_size;
        end
    end

    assign n_b1 = 32'((64'(r_b1) * 64'(B1_Q32) + 64'h8000_0000) >> 32);
    assign n_b2 = 32'((64'(r_b2) * 64'(B2_Q32) + 64'h8000_0000) >> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1 <= ONE_Q31;
            r_b2 <= ONE_Q31;
        end else if (acc && i_item.new_step) begin
            r_b1 <= n_b1;
            r_b2 <= n_b2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // accept stage: gradient products, power update, index wrap estimate
    assign gmag  = i_item.gradient[31] ? (~i_item.gradient + 32'd1) : i_item.gradient;
    assign gsq   = 64'(gmag) * 64'(gmag);
    assign mod_q = 37'(i_item.index) * 37'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p <= 1'b0;
        end else if (en) begin
            r_vld_p <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx_p  <= i_item.index;
            r_w_p    <= i_item.weight_in;
            r_gneg_p <= i_item.gradient[31];
            r_gm1_p  <= 32'((64'(gmag) * 64'(OMB1_Q32) + 64'h8000_0000) >> 32);
            r_g2_p   <= 55'((gsq + 64'd128) >> 8);
            r_b1_p   <= i_item.new_step ? n_b1 : r_b1;
            r_b2_p   <= i_item.new_step ? n_b2 : r_b2;
            r_q0_p   <= mod_q[MOD_SHIFT +: IDX_W];
        end
    end

    // address stage
    assign mod_prod = 29'(r_q0_p) * 29'(ENTRIES);
    assign mod_diff = 29'(r_idx_p) - mod_prod;
    assign mod_e    = (mod_diff >= 29'(ENTRIES)) ? mod_diff - 29'(ENTRIES) : mod_diff;
    assign e_p      = mod_e[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (en) begin
            r_vld_a <= r_vld_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx_a  <= r_idx_p;
            r_w_a    <= r_w_p;
            r_e_a    <= e_p;
            r_gneg_a <= r_gneg_p;
            r_gm1_a  <= r_gm1_p;
            r_gv_a   <= 46'((78'(r_g2_p) * 78'(OMB2_Q32) + 78'h8000_0000) >> 32);
            r_d1_a   <= (r_b1_p >= ONE_Q31) ? '0 : ONE_Q31 - r_b1_p;
            r_d2_a   <= (r_b2_p >= ONE_Q31) ? '0 : ONE_Q31 - r_b2_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_m[r_clr_addr] <= '0;
            mem_v[r_clr_addr] <= '0;
        end else if (en && r_vld_a) begin
            mem_m[r_e_a] <= m_new;
            mem_v[r_e_a] <= v_new;
        end
        if (en) begin
            r_rd_m <= mem_m[e_p];
            r_rd_v <= mem_v[e_p];
        end
    end

    // moment update, forwarding the write that the read missed
    assign fwd      = r_h_vld && (r_h_e == r_e_a);
    assign m_old    = fwd ? r_h_m : r_rd_m;
    assign v_old    = fwd ? r_h_v : r_rd_v;
    assign mmag_old = m_old[31] ? (~m_old + 32'd1) : m_old;
    assign pm       = 32'((64'(mmag_old) * 64'(B1_Q32) + 64'h8000_0000) >> 32);
    assign tm       = m_old[31] ? -$signed(34'(pm)) : $signed(34'(pm));
    assign tg       = r_gneg_a ? -$signed(34'(r_gm1_a)) : $signed(34'(r_gm1_a));
    assign sm       = tm + tg;
    assign m_new    = (sm > 34'sd2147483647) ? 32'h7FFF_FFFF :
                      (sm < -34'sd2147483648) ? 32'h8000_0000 : sm[31:0];
    assign vx       = 71'(v_old) * 71'(OMB2_Q32);
    assign pv       = v_old - 48'((vx + 71'h7FFF_FFFF) >> 32);
    assign vs       = 49'(pv) + 49'(r_gv_a);
    assign v_new    = vs[48] ? '1 : vs[47:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
            r_vld_x <= 1'b0;
        end else if (en) begin
            r_vld_x <= r_vld_a;
            if (r_vld_a) begin
                r_h_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_vld_a) begin
                r_h_e <= r_e_a;
                r_h_m <= m_new;
                r_h_v <= v_new;
            end
            r_tag_x.idx    <= r_idx_a;
            r_tag_x.w      <= r_w_a;
            r_tag_x.neg    <= m_new[31];
            r_tag_x.nostep <= (r_d1_a == '0) || (r_d2_a == '0);
            r_mmag_x       <= m_new[31] ? (~m_new + 32'd1) : m_new;
            r_v_x          <= v_new;
            r_d1_x         <= r_d1_a;
            r_d2_x         <= r_d2_a;
        end
    end

    // mhat = |m| * 2^31 / d1 and vhat = v * 2^31 / d2, one quotient bit a stage (mhat only in the first M_STAGES)
    for (genvar k = 0; k < D_STAGES; k++) begin : g_div
        logic        vld_i;
        t_tag        tag_i;
        logic [31:0] vrem_i;
        logic [61:0] vn_i;
        logic [61:0] vq_i;
        logic [31:0] d2_i;
        logic        vsat_i;
        logic [31:0] mrem_i;
        logic [37:0] mn_i;
        logic [37:0] mq_i;
        logic [31:0] d1_i;
        logic        msat_i;
        logic [32:0] vr2;
        logic [32:0] mr2;

        if (k == 0) begin : g_first
            assign vld_i  = r_vld_x;
            assign tag_i  = r_tag_x;
            assign vrem_i = 32'(r_v_x[47:31]);
            assign vn_i   = {r_v_x[30:0], 31'b0};
            assign vq_i   = '0;
            assign d2_i   = r_d2_x;
            assign vsat_i = 63'(r_v_x) >= {r_d2_x, 31'b0};
            assign mrem_i = 32'(r_mmag_x[31:7]);
            assign mn_i   = {r_mmag_x[6:0], 31'b0};
            assign mq_i   = '0;
            assign d1_i   = r_d1_x;
            assign msat_i = 39'(r_mmag_x) >= {r_d1_x, 7'b0};
        end else begin : g_next
            assign vld_i  = r_vld_d[k-1];
            assign tag_i  = r_tag_d[k-1];
            assign vrem_i = r_vrem_d[k-1];
            assign vn_i   = r_vn_d[k-1];
            assign vq_i   = r_vq_d[k-1];
            assign d2_i   = r_d2_d[k-1];
            assign vsat_i = r_vsat_d[k-1];
            assign mrem_i = r_mrem_d[k-1];
            assign mn_i   = r_mn_d[k-1];
            assign mq_i   = r_mq_d[k-1];
            assign d1_i   = r_d1_d[k-1];
            assign msat_i = r_msat_d[k-1];
        end

        assign vr2 = {vrem_i, vn_i[61]};
        assign mr2 = {mrem_i, mn_i[37]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_d[k] <= 1'b0;
            end else if (en) begin
                r_vld_d[k] <= vld_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_tag_d[k]  <= tag_i;
                r_d2_d[k]   <= d2_i;
                r_vsat_d[k] <= vsat_i;
                r_d1_d[k]   <= d1_i;
                r_msat_d[k] <= msat_i;
                r_vn_d[k]   <= {vn_i[60:0], 1'b0};
                if (vr2 >= {1'b0, d2_i}) begin
                    r_vrem_d[k] <= 32'(vr2 - {1'b0, d2_i});
                    r_vq_d[k]   <= {vq_i[60:0], 1'b1};
                end else begin
                    r_vrem_d[k] <= vr2[31:0];
                    r_vq_d[k]   <= {vq_i[60:0], 1'b0};
                end
                if (k < M_STAGES) begin
                    r_mn_d[k] <= {mn_i[36:0], 1'b0};
                    if (mr2 >= {1'b0, d1_i}) begin
                        r_mrem_d[k] <= 32'(mr2 - {1'b0, d1_i});
                        r_mq_d[k]   <= {mq_i[36:0], 1'b1};
                    end else begin
                        r_mrem_d[k] <= mr2[31:0];
                        r_mq_d[k]   <= {mq_i[36:0], 1'b0};
                    end
                end else begin
                    r_mn_d[k]   <= mn_i;
                    r_mrem_d[k] <= mrem_i;
                    r_mq_d[k]   <= mq_i;
                end
            end
        end
    end

    // truncated root of vhat * 2^8, one result bit a stage
    for (genvar k = 0; k < S_STAGES; k++) begin : g_sqrt
        logic        vld_i;
        t_tag        tag_i;
        logic [37:0] rem_i;
        logic [69:0] sn_i;
        logic [34:0] root_i;
        logic [37:0] mhat_i;
        logic [39:0] rsh;
        logic [36:0] trial;

        if (k == 0) begin : g_first
            assign vld_i  = r_vld_d[D_STAGES-1];
            assign tag_i  = r_tag_d[D_STAGES-1];
            assign rem_i  = '0;
            assign sn_i   = {(r_vsat_d[D_STAGES-1] ? {62{1'b1}} : r_vq_d[D_STAGES-1]), 8'b0};
            assign root_i = '0;
            assign mhat_i = r_msat_d[D_STAGES-1] ? '1 : r_mq_d[D_STAGES-1];
        end else begin : g_next
            assign vld_i  = r_vld_s[k-1];
            assign tag_i  = r_tag_s[k-1];
            assign rem_i  = r_rem_s[k-1];
            assign sn_i   = r_sn_s[k-1];
            assign root_i = r_root_s[k-1];
            assign mhat_i = r_mhat_s[k-1];
        end

        assign rsh   = {rem_i, sn_i[69:68]};
        assign trial = {root_i, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_s[k] <= 1'b0;
            end else if (en) begin
                r_vld_s[k] <= vld_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_tag_s[k]  <= tag_i;
                r_mhat_s[k] <= mhat_i;
                r_sn_s[k]   <= {sn_i[67:0], 2'b00};
                if (rsh >= 40'(trial)) begin
                    r_rem_s[k]  <= 38'(rsh - 40'(trial));
                    r_root_s[k] <= {root_i[33:0], 1'b1};
                end else begin
                    r_rem_s[k]  <= rsh[37:0];
                    r_root_s[k] <= {root_i[33:0], 1'b0};
                end
            end
        end
    end

    // ratio = mhat * 2^24 / (root + 1), one quotient bit a stage
    for (genvar k = 0; k < R_STAGES; k++) begin : g_ratio
        logic        vld_i;
        t_tag        tag_i;
        logic [35:0] rem_i;
        logic [61:0] rn_i;
        logic [61:0] q_i;
        logic [35:0] den_i;
        logic [36:0] r2;

        if (k == 0) begin : g_first
            assign vld_i = r_vld_s[S_STAGES-1];
            assign tag_i = r_tag_s[S_STAGES-1];
            assign rem_i = '0;
            assign rn_i  = {r_mhat_s[S_STAGES-1], 24'b0};
            assign q_i   = '0;
            assign den_i = 36'(r_root_s[S_STAGES-1]) + 36'd1;
        end else begin : g_next
            assign vld_i = r_vld_r[k-1];
            assign tag_i = r_tag_r[k-1];
            assign rem_i = r_rem_r[k-1];
            assign rn_i  = r_rn_r[k-1];
            assign q_i   = r_q_r[k-1];
            assign den_i = r_den_r[k-1];
        end

        assign r2 = {rem_i, rn_i[61]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_r[k] <= 1'b0;
            end else if (en) begin
                r_vld_r[k] <= vld_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_tag_r[k] <= tag_i;
                r_den_r[k] <= den_i;
                r_rn_r[k]  <= {rn_i[60:0], 1'b0};
                if (r2 >= {1'b0, den_i}) begin
                    r_rem_r[k] <= 36'(r2 - {1'b0, den_i});
                    r_q_r[k]   <= {q_i[60:0], 1'b1};
                end else begin
                    r_rem_r[k] <= r2[35:0];
                    r_q_r[k]   <= {q_i[60:0], 1'b0};
                end
            end
        end
    end

    // step size scaling and final weight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m1 <= 1'b0;
            r_vld_m2 <= 1'b0;
        end else if (en) begin
            r_vld_m1 <= r_vld_r[R_STAGES-1];
            r_vld_m2 <= r_vld_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag_m1  <= r_tag_r[R_STAGES-1];
            r_lo_m1   <= 64'(r_q_r[R_STAGES-1][31:0]) * 64'(r_lr);
            r_hi_m1   <= 62'(r_q_r[R_STAGES-1][61:32]) * 62'(r_lr);
            r_tag_m2  <= r_tag_m1;
            r_step_m2 <= 63'(r_hi_m1) + 63'((65'(r_lo_m1) + 65'h8000_0000) >> 32);
        end
    end

    assign wx  = {{33{r_tag_m2.w[31]}}, r_tag_m2.w};
    assign sx  = {2'b00, r_step_m2};
    assign rs  = r_tag_m2.neg ? wx + sx : wx - sx;
    assign res = r_tag_m2.nostep ? r_tag_m2.w :
                 (rs > 65'sd2147483647) ? 32'h7FFF_FFFF :
                 (rs < -65'sd2147483648) ? 32'h8000_0000 : rs[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en && r_vld_m2) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld_m2) begin
            r_out_idx <= r_tag_m2.idx;
            r_out_w   <= res;
        end
    end

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import awu_pkg::*;

    localparam logic [31:0] LR_MAX = 32'hFFFF_FFFF;
    localparam int LATENCY = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [31:0]      w;
    } t_weight_result;

    class adam_scoreboard;
        logic signed [31:0] m_mem [ENTRIES_DEF];
        logic [47:0]        v_mem [ENTRIES_DEF];
        logic [31:0]        b1_pow;
        logic [31:0]        b2_pow;
        logic [31:0]        lr;
        t_weight_result     pending_weights [$];
        int                 mismatches;

        function new();
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                m_mem[i] = '0;
                v_mem[i] = '0;
            end
            b1_pow = ONE_Q31;
            b2_pow = ONE_Q31;
            lr = LR_RESET;
            mismatches = 0;
        endfunction

        function automatic logic [63:0] mul_q32(logic [63:0] a, logic [31:0] b);
            logic [63:0] lo;
            logic [63:0] hi;
            lo = {32'd0, a[31:0]} * {32'd0, b};
            hi = {32'd0, a[63:32]} * {32'd0, b};
            return hi + ((lo + 64'h8000_0000) >> 32);
        endfunction

        function automatic longint smul_q32(longint a, logic [31:0] b);
            logic [63:0] mag;
            longint r;
            mag = (a < 0) ? -a : a;
            r = longint'(mul_q32(mag, b));
            return (a < 0) ? -r : r;
        endfunction

        function automatic longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function automatic logic [63:0] isqrt_q24(logic [63:0] x);
            logic [63:0] rem;
            logic [63:0] root;
            logic [63:0] pair;
            logic [63:0] trial;
            rem = 0;
            root = 0;
            for (int i = 35; i >= 0; i--) begin
                pair = (i >= 4) ? ((x >> (2 * i - 8)) & 64'd3) : 64'd0;
                rem = (rem << 2) | pair;
                trial = (root << 2) | 64'd1;
                if (rem >= trial) begin
                    rem -= trial;
                    root = (root << 1) | 64'd1;
                end else begin
                    root = root << 1;
                end
            end
            return root;
        endfunction

        function void note_item(logic [IDX_W-1:0] idx, logic [31:0] w_in,
                                logic [31:0] g_in, logic step);
            int e;
            longint w, g, m, res;
            logic [63:0] gmag, g2, v, d1, d2, mmag, mhat, q, vhat, den, ratio, stp;
            t_weight_result r;
            e = idx % ENTRIES_DEF;
            w = longint'($signed(w_in));
            g = longint'($signed(g_in));
            res = w;
            if (step) begin
                b1_pow = mul_q32({32'd0, b1_pow}, B1_Q32);
                b2_pow = mul_q32({32'd0, b2_pow}, B2_Q32);
            end
            m = sat32(smul_q32(longint'(m_mem[e]), B1_Q32) + smul_q32(g, OMB1_Q32));
            m_mem[e] = m[31:0];
            gmag = (g < 0) ? -g : g;
            g2 = (gmag * gmag + 64'd128) >> 8;
            v = mul_q32({16'd0, v_mem[e]}, B2_Q32) + mul_q32(g2, OMB2_Q32);
            if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
            v_mem[e] = v[47:0];
            d1 = (b1_pow >= ONE_Q31) ? 64'd0 : {32'd0, ONE_Q31 - b1_pow};
            d2 = (b2_pow >= ONE_Q31) ? 64'd0 : {32'd0, ONE_Q31 - b2_pow};
            if (d1 != 0 && d2 != 0) begin
                mmag = (m < 0) ? -m : m;
                mhat = (mmag << 31) / d1;
                q = v / d2;
                if (mhat > 64'h3F_FFFF_FFFF) mhat = 64'h3F_FFFF_FFFF;
                if (q >= 64'h8000_0000) vhat = 64'h3FFF_FFFF_FFFF_FFFF;
                else vhat = (q << 31) + (((v % d2) << 31) / d2);
                if (vhat > 64'h3FFF_FFFF_FFFF_FFFF) vhat = 64'h3FFF_FFFF_FFFF_FFFF;
                den = isqrt_q24(vhat) + 64'd1;
                ratio = (mhat << 24) / den;
                stp = mul_q32(ratio, lr);
                res = sat32((m < 0) ? w + longint'(stp) : w - longint'(stp));
            end
            r.idx = idx;
            r.w = res[31:0];
            pending_weights.push_back(r);
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [31:0] w);
            t_weight_result exp_r;
            if (pending_weights.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result idx=%0d w=%h", idx, w);
                return;
            end
            exp_r = pending_weights.pop_front();
            if (exp_r.idx !== idx || exp_r.w !== w) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected idx=%0d w=%h, actual idx=%0d w=%h",
                             exp_r.idx, exp_r.w, idx, w);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    awu_cfg_if cfg_bus ();
    awu_in_if item_bus ();
    awu_out_if result_bus ();

    adam_weight_update u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus.sink),
        .i_item   (item_bus.sink),
        .o_result (result_bus.source)
    );

    adam_scoreboard sb;
    int  idle_cycles;
    bit  stim_done;
    bit  hold_sink;
    int  sink_hold_cycles;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        cfg_bus.valid = 1'b0;
        cfg_bus.step_size = '0;
        item_bus.valid = 1'b0;
        item_bus.index = '0;
        item_bus.weight_in = '0;
        item_bus.gradient = '0;
        item_bus.new_step = 1'b0;
        result_bus.ready = 1'b0;
    end

    task automatic write_lr(logic [31:0] lr);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.step_size = lr;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.lr = lr;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic send_item(logic [IDX_W-1:0] idx, logic [31:0] w, logic [31:0] g,
                             logic step);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) @(negedge i_clk);
        item_bus.valid = 1'b1;
        item_bus.index = idx;
        item_bus.weight_in = w;
        item_bus.gradient = g;
        item_bus.new_step = step;
        do @(posedge i_clk); while (!item_bus.ready);
        sb.note_item(idx, w, g, step);
        @(negedge i_clk);
        item_bus.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_weights.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0100_0000);
            3: return -$urandom_range(0, 32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n, int idx_span);
        for (int i = 0; i < n; i++)
            send_item(IDX_W'($urandom_range(0, idx_span)), rand_value(), rand_value(),
                      ($urandom_range(0, 3) == 0));
    endtask

    always @(posedge i_clk) begin
        if (result_bus.valid && result_bus.ready)
            sb.check_result(result_bus.index_out, result_bus.weight_out);
    end

    always @(negedge i_clk) begin
        if (hold_sink) begin
            result_bus.ready <= 1'b0;
        end else if (sink_hold_cycles > 0) begin
            sink_hold_cycles <= sink_hold_cycles - 1;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= 1'b1;
            if (result_bus.valid && result_bus.ready && $urandom_range(0, 1))
                sink_hold_cycles <= $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || stim_done || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        sb = new();
        stim_done = 1'b0;
        hold_sink = 1'b0;
        sink_hold_cycles = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(12'd0, 32'h0100_0000, 32'h0100_0000, 1'b0);
        send_item(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_item(12'd0, 32'h0100_0000, 32'h0080_0000, 1'b1);
        send_item(12'd0, 32'h0100_0000, 32'h0080_0000, 1'b0);
        send_item(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_item(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_item(12'd1, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_item(12'd2, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_item(12'd3, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_item(12'd2, 32'h8000_0001, 32'h7FFF_FFFF, 1'b1);
        drain();

        write_lr(LR_MAX);
        send_item(12'd5, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        send_item(12'd6, 32'h7FFF_FFF0, 32'h8000_0000, 1'b0);
        send_item(12'd6, 32'h8000_0010, 32'h7FFF_FFFF, 1'b1);
        send_item(12'd7, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        drain();
        write_lr(32'd0);
        send_item(12'd5, 32'h1234_5678, 32'h0100_0000, 1'b1);
        send_item(12'd8, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        drain();

        write_lr(LR_RESET);
        random_phase(400, 4095);
        drain();
        write_lr($urandom);
        random_phase(250, 15);

        hold_sink = 1'b1;
        fork
            random_phase(200, 31);
            begin
                repeat (600) @(negedge i_clk);
                hold_sink = 1'b0;
            end
        join
        drain();

        write_lr(LR_MAX);
        random_phase(200, 4095);
        drain();
        write_lr($urandom_range(0, 32'h00FF_FFFF));
        random_phase(200, 7);
        drain();

        stim_done = 1'b1;
        if (sb.mismatches == 0 && sb.pending_weights.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/awu_pkg.sv
rtl/awu_if.sv
rtl/adam_weight_update.sv
dv/tb.sv
